### rtl/pairwise_proximity_checker_core_assert.svh
// assertion macros shared by the rtl, sampled on clk and disabled during rst
`ifndef PAIRWISE_PROXIMITY_CHECKER_CORE_ASSERT_SVH
`define PAIRWISE_PROXIMITY_CHECKER_CORE_ASSERT_SVH

// same-cycle implication
`define PPC_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPC_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ppc_pkg.sv
`default_nettype none
package ppc_pkg;

  localparam int MAX_NODES  = 8;
  localparam int COORD_BITS = 24;
  localparam int SAFETY_W   = 24;
  localparam int COUNT_W    = 4;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SAFETY_DISTANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT      = 1'b1;

  localparam logic KIND_PAIR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } pos_t;

  typedef struct packed {
    logic                         present;
    logic                         arrived;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] first_node;
    logic [2:0] second_node;
    logic [7:0] collided_mask;
    logic [3:0] arrived_now;
    logic       all_arrived;
    logic       last;
  } result_t;

  typedef struct packed {
    logic done;
    logic close;
  } dist_res_t;

endpackage
`default_nettype wire

### rtl/ppc_store.sv
`default_nettype none
module ppc_store #(
  parameter int DEPTH = 8
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire ppc_pkg::pos_t              wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_b,
  output ppc_pkg::pos_t                   rd_a,
  output ppc_pkg::pos_t                   rd_b
);
  import ppc_pkg::*;

  pos_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

endmodule
`default_nettype wire

### rtl/ppc_dist.sv
`default_nettype none
module ppc_dist (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            run,
  input  wire ppc_pkg::pos_t                   coord_a,
  input  wire ppc_pkg::pos_t                   coord_b,
  input  wire logic [ppc_pkg::SAFETY_W-1:0]    safety,
  output ppc_pkg::dist_res_t                   res
);
  import ppc_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 2;

  typedef enum logic [4:0] {
    STEP_X    = 5'b00001,
    STEP_Y    = 5'b00010,
    STEP_Z    = 5'b00100,
    STEP_LAST = 5'b01000,
    STEP_DONE = 5'b10000
  } step_t;

  step_t                        step;
  step_t                        step_next;
  logic signed [COORD_BITS-1:0] ca;
  logic signed [COORD_BITS-1:0] cb;
  logic signed [DW-1:0]         diff;
  logic [DW-1:0]                mag;
  logic                         far_now;
  logic [DW-1:0]                mul_in;
  logic [DW-1:0]                d;
  logic [PW-1:0]                prod;
  logic [PW-1:0]                thr;
  logic [SW-1:0]                acc;
  logic                         far;
  logic [SW-1:0]                sum;

  always_comb begin
    case (step)
      STEP_X: begin
        ca = coord_a.x;
        cb = coord_b.x;
      end
      STEP_Y: begin
        ca = coord_a.y;
        cb = coord_b.y;
      end
      STEP_Z: begin
        ca = coord_a.z;
        cb = coord_b.z;
      end
      default: begin
        ca = coord_a.x;
        cb = coord_b.x;
      end
    endcase
    diff    = DW'(ca) - DW'(cb);
    mag     = diff[DW-1] ? DW'(-diff) : DW'(diff);
    far_now = mag > DW'(safety);
    // first step squares the threshold, later steps square the axis gaps
    mul_in  = (step == STEP_X) ? DW'(safety) : d;
    sum     = acc + SW'(prod);
  end

  always_comb begin
    case (step)
      STEP_X:    step_next = STEP_Y;
      STEP_Y:    step_next = STEP_Z;
      STEP_Z:    step_next = STEP_LAST;
      STEP_LAST: step_next = STEP_DONE;
      default:   step_next = STEP_X;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_X;
    end else if (run) begin
      step <= step_next;
    end else begin
      step <= STEP_X;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      case (step)
        STEP_X: begin
          prod <= mul_in * mul_in;
          d    <= mag;
          far  <= far_now;
        end
        STEP_Y: begin
          thr  <= prod;
          prod <= mul_in * mul_in;
          d    <= mag;
          far  <= far | far_now;
        end
        STEP_Z: begin
          acc  <= SW'(prod);
          prod <= mul_in * mul_in;
          d    <= mag;
          far  <= far | far_now;
        end
        STEP_LAST: begin
          acc  <= sum;
          prod <= mul_in * mul_in;
        end
        default: begin
        end
      endcase
    end
  end

  assign res.done  = run && (step == STEP_DONE);
  assign res.close = !far && (sum <= SW'(thr));

endmodule
`default_nettype wire

### rtl/pairwise_proximity_checker_core.sv
`default_nettype none
// Pairwise proximity checker. Node items come in slot order, one beat each, and
// are taken at one per cycle; present nodes that have not arrived are stored and
// take part in the round, present nodes that have arrived are counted. After the
// last slot of a round the block stops taking items and walks every slot pair
// i<j: each candidate pair is checked, and a pair with both nodes taking part
// goes through the shared squared-distance unit (one 25x25 multiplier that
// squares the threshold and then the three axis gaps, with an accumulator); a
// pair found within the safety distance is handed over as a collision report.
// The summary beat closes the round. The walk is bounded by the single
// multiplier. A finished beat waits in the output register while the next
// round loads.
module pairwise_proximity_checker_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               item_valid,
  output logic                                    item_stall,
  input  wire ppc_pkg::item_t                     item,
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output ppc_pkg::result_t                        result,
  input  wire logic                               cfg_write,
  input  wire logic [ppc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ppc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ppc_pkg::*;

`include "pairwise_proximity_checker_core_assert.svh"

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_NODES);

  typedef enum logic [4:0] {
    S_LOAD    = 5'b00001,
    S_WALK    = 5'b00010,
    S_CALC    = 5'b00100,
    S_EMIT    = 5'b01000,
    S_SUMMARY = 5'b10000
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [SAFETY_W-1:0]   safety_distance;
  logic [COUNT_W-1:0]    node_count;
  logic [MAX_NODES-1:0]  valid_mask;
  logic [MAX_NODES-1:0]  valid_load;
  logic [MAX_NODES-1:0]  collided;
  logic [MAX_NODES-1:0]  pair_bits;
  logic [IW-1:0]         load_index;
  logic [COUNT_W-1:0]    round_arrivals;
  logic [COUNT_W-1:0]    total_arrivals;
  logic [CW-1:0]         n_eff;
  logic [CW-1:0]         i;
  logic [CW-1:0]         j;
  logic [CW:0]           i_inc1;
  logic [CW:0]           i_inc2;
  logic [CW-1:0]         j_inc1;
  logic                  item_accept;
  logic                  load_last;
  logic                  took_part;
  logic                  arrival;
  logic                  pair_left;
  logic                  both_valid;
  logic                  out_free;
  logic                  out_load;
  logic                  pair_ok;
  logic                  round_done;
  logic                  round_clear;
  result_t               result_next;
  pos_t                  wr_pos;
  pos_t                  rd_a;
  pos_t                  rd_b;
  dist_res_t             dist_res;

  always_comb begin
    if (node_count < COUNT_W'(2)) begin
      n_eff = CW'(2);
    end else if (node_count > MAX_CNT) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = CW'(node_count);
    end
  end

  assign item_stall  = (state != S_LOAD);
  assign item_accept = item_valid && (state == S_LOAD);
  assign took_part   = item.present && !item.arrived;
  assign arrival     = item.present && item.arrived;
  assign load_last   = (CW'(load_index) + CW'(1)) >= n_eff;

  assign i_inc1     = {1'b0, i} + (CW+1)'(1);
  assign i_inc2     = {1'b0, i} + (CW+1)'(2);
  assign j_inc1     = j + CW'(1);
  assign pair_left  = i_inc1 < {1'b0, n_eff};
  assign both_valid = valid_mask[i[IW-1:0]] && valid_mask[j[IW-1:0]];

  assign out_free = !result_valid || !result_stall;
  assign out_load = ((state == S_EMIT) || (state == S_SUMMARY)) && out_free;

  always_comb begin
    valid_load                = valid_mask;
    valid_load[load_index]    = took_part;
    pair_bits                 = '0;
    pair_bits[i[IW-1:0]]      = 1'b1;
    pair_bits[j[IW-1:0]]      = 1'b1;
  end

  assign wr_pos.x = item.pos_x;
  assign wr_pos.y = item.pos_y;
  assign wr_pos.z = item.pos_z;

  ppc_store #(
    .DEPTH(MAX_NODES)
  ) u_store (
    .clk       (clk),
    .wr_en     (item_accept && took_part),
    .wr_addr   (load_index),
    .wr_data   (wr_pos),
    .rd_addr_a (i[IW-1:0]),
    .rd_addr_b (j[IW-1:0]),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  ppc_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .run     (state == S_CALC),
    .coord_a (rd_a),
    .coord_b (rd_b),
    .safety  (safety_distance),
    .res     (dist_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (item_accept && load_last) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (!pair_left) begin
          state_next = S_SUMMARY;
        end else if ((j < n_eff) && both_valid) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (dist_res.done) begin
          state_next = dist_res.close ? S_EMIT : S_WALK;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_WALK;
        end
      end
      S_SUMMARY: begin
        if (out_free) begin
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_LOAD;
      safety_distance <= SAFETY_W'(256);
      node_count      <= COUNT_W'(8);
      valid_mask      <= '0;
      collided        <= '0;
      load_index      <= '0;
      round_arrivals  <= '0;
      total_arrivals  <= '0;
      i               <= '0;
      j               <= '0;
      result_valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          CFG_SAFETY_DISTANCE: safety_distance <= cfg_data[SAFETY_W-1:0];
          CFG_NODE_COUNT:      node_count      <= cfg_data[COUNT_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_LOAD: begin
          if (item_accept) begin
            valid_mask <= valid_load;
            if (arrival) begin
              round_arrivals <= round_arrivals + COUNT_W'(1);
              if (total_arrivals != '1) begin
                total_arrivals <= total_arrivals + COUNT_W'(1);
              end
            end
            if (load_last) begin
              load_index <= '0;
              i          <= '0;
              j          <= CW'(1);
            end else begin
              load_index <= load_index + IW'(1);
            end
          end
        end
        S_WALK: begin
          if (pair_left) begin
            if (j >= n_eff) begin
              i <= i_inc1[CW-1:0];
              j <= i_inc2[CW-1:0];
            end else if (!both_valid) begin
              j <= j_inc1;
            end
          end
        end
        S_CALC: begin
          if (dist_res.done) begin
            if (dist_res.close) begin
              collided <= collided | pair_bits;
            end else begin
              j <= j_inc1;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            j <= j_inc1;
          end
        end
        S_SUMMARY: begin
          if (out_free) begin
            valid_mask     <= '0;
            collided       <= '0;
            round_arrivals <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result_next = '0;
    if (state == S_SUMMARY) begin
      result_next.kind          = KIND_SUMMARY;
      result_next.collided_mask = 8'(collided);
      result_next.arrived_now   = round_arrivals;
      result_next.all_arrived   = (total_arrivals == node_count);
      result_next.last          = 1'b1;
    end else begin
      result_next.kind        = KIND_PAIR;
      result_next.first_node  = 3'(i);
      result_next.second_node = 3'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= result_next;
    end
  end

  assign pair_ok     = both_valid && (i < j) && (j < n_eff);
  assign round_done  = (state == S_SUMMARY) && out_free;
  assign round_clear = (valid_mask == '0) && (collided == '0);

  `PPC_CHECK(a_done_in_calc, dist_res.done, state == S_CALC, "distance unit done outside calc")
  `PPC_CHECK(a_emit_pair_ok, state == S_EMIT, pair_ok, "bad pair report")
  `PPC_CHECK_NEXT(a_round_cleared, round_done, (state == S_LOAD) && round_clear, "round not cleared")
  `PPC_CHECK_NEXT(a_total_grows, 1'b1, total_arrivals >= $past(total_arrivals), "arrival total dropped")

endmodule
`default_nettype wire
